// ===== hw/rtl/fdd_pkg.sv =====
// ----------------------------------------------------------------------------
// fdd_pkg
// shared types, codes and helpers of the fingerprint delta decoder
// ----------------------------------------------------------------------------
`default_nettype none

package fdd_pkg;

  localparam int DEF_MAX_BYTES = 4096;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_HDR_SHORT = 3'd1;
  localparam logic [2:0] STAT_SYM_SHORT = 3'd2;
  localparam logic [2:0] STAT_EXC_SHORT = 3'd3;
  localparam logic [2:0] STAT_TOO_LONG  = 3'd4;
  localparam logic [2:0] STAT_NONE      = 3'd5;

  localparam logic [2:0] SYM_ZERO = 3'd0;
  localparam logic [2:0] SYM_ESC  = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC_START,
    S_SYM_TEST,
    S_GB0,
    S_GB1,
    S_GB2,
    S_CHECK,
    S_EXC_RD,
    S_EXC_CHK,
    S_FINISH,
    S_FETCH_TEST,
    S_FETCH_CHK,
    S_FETCH_DONE,
    S_EMIT
  } fdd_state_t;

  typedef struct packed {
    logic        is_value;
    logic [31:0] decoded_value;
    logic [13:0] value_index;
    logic        last_value;
    logic [23:0] value_count;
    logic [2:0]  status;
  } res_t;

  // url-safe alphabet, anything else maps to zero
  function automatic logic [5:0] b64_char_value(input logic [7:0] c);
    logic [5:0] v;
    v = 6'd0;
    if (c inside {["A":"Z"]}) begin
      v = 6'(c - 8'd65);
    end else if (c inside {["a":"z"]}) begin
      v = 6'(c - 8'd97 + 8'd26);
    end else if (c inside {["0":"9"]}) begin
      v = 6'(c - 8'd48 + 8'd52);
    end else if (c == 8'd45) begin
      v = 6'd62;
    end else if (c == 8'd95) begin
      v = 6'd63;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fingerprint_delta_decoder.sv =====
// ----------------------------------------------------------------------------
// fingerprint_delta_decoder
// a load transfer is taken from idle; the final load runs the decode: a symbol
// pass, then an exception pass that rereads each symbol and extracts an escape's
// bits, both via the shared two-byte bit extractor on the single-port byte store
// a fetch walks the symbol store in a read loop
// one transfer in flight at a time; synchronous active-low reset empties all
// ----------------------------------------------------------------------------
`default_nettype none

module fingerprint_delta_decoder #(
  parameter int MAX_BYTES = fdd_pkg::DEF_MAX_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_final_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_is_value,
  output logic [31:0]      out_decoded_value,
  output logic [13:0]      out_value_index,
  output logic             out_last_value,
  output logic [23:0]      out_value_count,
  output logic [2:0]       out_status
);
  import fdd_pkg::*;

  // base64 mode register; the user must write it only while idle, the block does not enforce it
  logic mode_r, mode_nxt;

  // handshake between front end and sequencer
  logic core_idle;
  logic in_take;
  logic load_take;
  logic byte_valid;
  logic [7:0] byte_data;

  // result hand-over into the output register
  logic res_valid;
  res_t res;
  logic res_room;
  logic out_valid_r, out_valid_nxt;
  res_t out_r;

  // the sequencer takes a transfer only from its idle state
  assign in_stall  = !core_idle;
  assign in_take   = in_valid && core_idle;
  assign load_take = in_take && (in_command == CMD_LOAD);

  // output register is free when empty or being drained this cycle
  assign res_room = !out_valid_r || !out_stall;

  assign mode_nxt = cfg_wr_en ? cfg_wr_data : mode_r;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (res_valid && res_room) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload held while stalled
  always_ff @(posedge clk) begin
    if (res_valid && res_room) out_r <= res;
  end

  // character to byte front end
  fdd_b64 u_b64 (
    .clk        (clk),
    .rst_n      (rst_n),
    .mode       (mode_r),
    .load_take  (load_take),
    .data       (in_data_byte),
    .final_load (in_final_byte),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  // stores, decode pass and fetch walk
  fdd_core #(
    .MAX_BYTES (MAX_BYTES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_take    (in_take),
    .in_command (in_command),
    .in_final   (in_final_byte),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .res_room   (res_room),
    .core_idle  (core_idle),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign out_valid         = out_valid_r;
  assign out_is_value      = out_r.is_value;
  assign out_decoded_value = out_r.decoded_value;
  assign out_value_index   = out_r.value_index;
  assign out_last_value    = out_r.last_value;
  assign out_value_count   = out_r.value_count;
  assign out_status        = out_r.status;

endmodule

`default_nettype wire

// ===== hw/rtl/fdd_b64.sv =====
// ----------------------------------------------------------------------------
// fdd_b64
// turns base64 characters, or raw bytes, into the byte stream being loaded
// ----------------------------------------------------------------------------
`default_nettype none

module fdd_b64 (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       mode,
  input  wire logic       load_take,
  input  wire logic [7:0] data,
  input  wire logic       final_load,
  output logic            byte_valid,
  output logic [7:0]      byte_data
);
  import fdd_pkg::*;

  logic [5:0] prev_r, prev_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [5:0] v;

  assign v = b64_char_value(data);

  always_comb begin
    byte_valid = 1'b1;
    byte_data  = data;
    if (mode) begin
      case (phase_r)
        2'd1: byte_data = {prev_r, v[5:4]};
        2'd2: byte_data = {prev_r[3:0], v[5:2]};
        2'd3: byte_data = {prev_r[1:0], v};
        default: begin
          byte_valid = 1'b0;
          byte_data  = 8'h00;
        end
      endcase
    end
  end

  always_comb begin
    prev_nxt  = prev_r;
    phase_nxt = phase_r;
    if (load_take) begin
      if (mode) begin
        prev_nxt  = v;
        phase_nxt = phase_r + 2'd1;
      end
      if (final_load) begin
        prev_nxt  = 6'd0;
        phase_nxt = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 6'd0;
      phase_r <= 2'd0;
    end else begin
      prev_r  <= prev_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fdd_core.sv =====
// ----------------------------------------------------------------------------
// fdd_core
// byte and symbol stores with the sequencer around a shared bit extractor
// ----------------------------------------------------------------------------
`default_nettype none

module fdd_core #(
  parameter int MAX_BYTES = fdd_pkg::DEF_MAX_BYTES
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_take,
  input  wire logic       in_command,
  input  wire logic       in_final,
  input  wire logic       byte_valid,
  input  wire logic [7:0] byte_data,
  input  wire logic       res_room,
  output logic            core_idle,
  output logic            res_valid,
  output fdd_pkg::res_t   res
);
  import fdd_pkg::*;

  localparam int AW        = $clog2(MAX_BYTES);
  localparam int CW        = AW + 1;
  localparam int BPW       = AW + 4;
  localparam int SYM_DEPTH = MAX_BYTES * 8 / 3;
  localparam int SAW       = $clog2(SYM_DEPTH);
  localparam int SW        = SAW + 1;

  fdd_state_t state_r, state_nxt;

  logic [7:0] byte_mem [MAX_BYTES];
  logic [5:0] sym_mem  [SYM_DEPTH];
  logic [7:0] brdata_r;
  logic [5:0] srdata_r;

  logic           bwe;
  logic [AW-1:0]  brd_addr;
  logic           swe;
  logic [SAW-1:0] saddr;
  logic [5:0]     swdata;

  logic [CW-1:0]  byte_cnt_r, byte_cnt_nxt;
  logic           ovf_r, ovf_nxt;
  logic [23:0]    hdr_r, hdr_nxt;
  logic [23:0]    total_r, total_nxt;
  logic [BPW-1:0] bitp_r, bitp_nxt;
  logic [BPW-1:0] gbit_r, gbit_nxt;
  logic [7:0]     lo_r, lo_nxt;
  logic [SW-1:0]  sym_i_r, sym_i_nxt;
  logic [SW-1:0]  used_r, used_nxt;
  logic [SW-1:0]  zeros_r, zeros_nxt;
  logic [BPW-1:0] want5_r, want5_nxt;
  logic [BPW-1:0] endbit_r, endbit_nxt;
  logic [BPW-1:0] exbit_r, exbit_nxt;
  logic           gb_exc_r, gb_exc_nxt;
  logic [SW-1:0]  symcnt_r, symcnt_nxt;
  logic [SW-1:0]  rp_r, rp_nxt;
  logic [31:0]    prev_r, prev_nxt;
  logic [23:0]    emitted_r, emitted_nxt;
  logic [2:0]     dstat_r, dstat_nxt;
  logic [31:0]    acc_r, acc_nxt;
  logic [5:0]     pos_r, pos_nxt;
  res_t           res_r, res_nxt;

  // shared conditions
  logic [BPW:0]   n8, sym_end, off_tmp, offbit;
  logic           sym_fits, n_ge4, n_le4, room_byte;
  logic [CW-1:0]  idx, idx1;
  logic [7:0]     hi;
  logic [15:0]    win;
  logic [SW-1:0]  zeros_inc, j_inc;
  logic           zero_hit, zeros_ne, exc_short, j_last;
  logic [23:0]    tv, emit_inc;
  logic           rp_more, fetch_none;
  logic [6:0]     psum;
  logic [5:0]     npos, npos_m1;

  assign n8        = {1'b0, byte_cnt_r, 3'b000};
  assign sym_end   = {1'b0, bitp_r} + (BPW+1)'(3);
  assign sym_fits  = sym_end <= n8;
  assign n_ge4     = byte_cnt_r >= CW'(4);
  assign n_le4     = byte_cnt_r <= CW'(4);
  assign room_byte = byte_cnt_r < CW'(MAX_BYTES);
  assign tv        = n_ge4 ? hdr_r : 24'd0;

  // shared bit extractor: two neighbouring bytes and a funnel shift
  assign idx  = gbit_r[BPW-1:3];
  assign idx1 = idx + CW'(1);
  assign hi   = (idx1 < byte_cnt_r) ? brdata_r : 8'h00;
  assign win  = {hi, lo_r} >> gbit_r[2:0];

  assign zeros_inc = zeros_r + SW'(1);
  assign zero_hit  = (win[2:0] == SYM_ZERO) && (24'(zeros_inc) == total_r);
  assign zeros_ne  = 24'(zeros_r) != total_r;
  assign off_tmp   = {1'b0, endbit_r} + (BPW+1)'(7);
  assign offbit    = {off_tmp[BPW:3], 3'b000};
  assign exc_short = (want5_r != '0) &&
                     ((offbit > n8) || ((n8 - offbit) < {1'b0, want5_r}));
  assign j_inc     = sym_i_r + SW'(1);
  assign j_last    = j_inc == used_r;

  assign rp_more    = rp_r < symcnt_r;
  assign fetch_none = (dstat_r != STAT_OK) || (emitted_r >= total_r);
  assign emit_inc   = emitted_r + 24'd1;
  assign psum       = {1'b0, pos_r} + {1'b0, srdata_r};
  assign npos       = (psum > 7'd63) ? 6'd63 : psum[5:0];
  assign npos_m1    = npos - 6'd1;

  assign brd_addr = (state_r == S_GB1) ? idx1[AW-1:0] : idx[AW-1:0];
  assign saddr    = (state_r == S_FETCH_TEST) ? rp_r[SAW-1:0] : sym_i_r[SAW-1:0];

  assign core_idle = state_r == S_IDLE;
  assign res_valid = state_r == S_EMIT;
  assign res       = res_r;

  // memories
  always_ff @(posedge clk) begin
    if (bwe) begin
      byte_mem[byte_cnt_r[AW-1:0]] <= byte_data;
    end
    brdata_r <= byte_mem[brd_addr];
  end

  always_ff @(posedge clk) begin
    if (swe) begin
      sym_mem[saddr] <= swdata;
    end
    srdata_r <= sym_mem[saddr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          if (in_command == CMD_LOAD) begin
            if (in_final) state_nxt = S_DEC_START;
          end else begin
            state_nxt = fetch_none ? S_EMIT : S_FETCH_TEST;
          end
        end
      end
      S_DEC_START:  state_nxt = (ovf_r || n_le4) ? S_EMIT : S_SYM_TEST;
      S_SYM_TEST:   state_nxt = sym_fits ? S_GB0 : S_CHECK;
      S_GB0:        state_nxt = S_GB1;
      S_GB1:        state_nxt = S_GB2;
      S_GB2: begin
        if (gb_exc_r) state_nxt = j_last ? S_FINISH : S_EXC_RD;
        else          state_nxt = zero_hit ? S_CHECK : S_SYM_TEST;
      end
      S_CHECK: begin
        if (zeros_ne || exc_short) state_nxt = S_EMIT;
        else                       state_nxt = (used_r == '0) ? S_FINISH : S_EXC_RD;
      end
      S_EXC_RD:     state_nxt = S_EXC_CHK;
      S_EXC_CHK: begin
        if (srdata_r == 6'(SYM_ESC)) state_nxt = S_GB0;
        else                         state_nxt = j_last ? S_FINISH : S_EXC_RD;
      end
      S_FINISH:     state_nxt = S_EMIT;
      S_FETCH_TEST: state_nxt = rp_more ? S_FETCH_CHK : S_FETCH_DONE;
      S_FETCH_CHK:  state_nxt = (srdata_r == 6'd0) ? S_FETCH_DONE : S_FETCH_TEST;
      S_FETCH_DONE: state_nxt = S_EMIT;
      S_EMIT:       state_nxt = res_room ? S_IDLE : S_EMIT;
      default:      state_nxt = S_IDLE;
    endcase
  end

  // datapath and store controls
  always_comb begin
    bwe          = 1'b0;
    swe          = 1'b0;
    swdata       = 6'd0;
    byte_cnt_nxt = byte_cnt_r;
    ovf_nxt      = ovf_r;
    hdr_nxt      = hdr_r;
    total_nxt    = total_r;
    bitp_nxt     = bitp_r;
    gbit_nxt     = gbit_r;
    lo_nxt       = lo_r;
    sym_i_nxt    = sym_i_r;
    used_nxt     = used_r;
    zeros_nxt    = zeros_r;
    want5_nxt    = want5_r;
    endbit_nxt   = endbit_r;
    exbit_nxt    = exbit_r;
    gb_exc_nxt   = gb_exc_r;
    symcnt_nxt   = symcnt_r;
    rp_nxt       = rp_r;
    prev_nxt     = prev_r;
    emitted_nxt  = emitted_r;
    dstat_nxt    = dstat_r;
    acc_nxt      = acc_r;
    pos_nxt      = pos_r;
    res_nxt      = res_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          if (in_command == CMD_LOAD) begin
            if (byte_valid) begin
              if (room_byte) begin
                bwe          = 1'b1;
                byte_cnt_nxt = byte_cnt_r + CW'(1);
                if (byte_cnt_r == CW'(1)) hdr_nxt[23:16] = byte_data;
                if (byte_cnt_r == CW'(2)) hdr_nxt[15:8]  = byte_data;
                if (byte_cnt_r == CW'(3)) hdr_nxt[7:0]   = byte_data;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
          end else if (fetch_none) begin
            res_nxt = '{is_value: 1'b0, decoded_value: 32'd0, value_index: 14'd0,
                        last_value: 1'b0, value_count: total_r, status: STAT_NONE};
          end else begin
            acc_nxt = 32'd0;
            pos_nxt = 6'd0;
          end
        end
      end
      S_DEC_START: begin
        total_nxt = tv;
        bitp_nxt  = BPW'(32);
        sym_i_nxt = '0;
        zeros_nxt = '0;
        want5_nxt = '0;
        if (ovf_r || n_le4) begin
          res_nxt = '{is_value: 1'b0, decoded_value: 32'd0, value_index: 14'd0,
                      last_value: 1'b0, value_count: tv,
                      status: ovf_r ? STAT_TOO_LONG : STAT_HDR_SHORT};
          dstat_nxt    = STAT_NONE;
          byte_cnt_nxt = '0;
          ovf_nxt      = 1'b0;
        end
      end
      S_SYM_TEST: begin
        gbit_nxt   = bitp_r;
        gb_exc_nxt = 1'b0;
        if (!sym_fits) begin
          endbit_nxt = bitp_r;
          used_nxt   = sym_i_r;
        end
      end
      S_GB1: begin
        lo_nxt = (idx < byte_cnt_r) ? brdata_r : 8'h00;
      end
      S_GB2: begin
        swe = 1'b1;
        if (gb_exc_r) begin
          swdata    = 6'(SYM_ESC) + {1'b0, win[4:0]};
          exbit_nxt = exbit_r + BPW'(5);
          sym_i_nxt = j_inc;
        end else begin
          swdata = {3'b000, win[2:0]};
          if (win[2:0] == SYM_ZERO) zeros_nxt = zeros_inc;
          if (win[2:0] == SYM_ESC)  want5_nxt = want5_r + BPW'(5);
          if (zero_hit) begin
            used_nxt   = j_inc;
            endbit_nxt = sym_end[BPW-1:0];
          end else begin
            sym_i_nxt = j_inc;
            bitp_nxt  = sym_end[BPW-1:0];
          end
        end
      end
      S_CHECK: begin
        exbit_nxt = offbit[BPW-1:0];
        sym_i_nxt = '0;
        if (zeros_ne || exc_short) begin
          res_nxt = '{is_value: 1'b0, decoded_value: 32'd0, value_index: 14'd0,
                      last_value: 1'b0, value_count: total_r,
                      status: zeros_ne ? STAT_SYM_SHORT : STAT_EXC_SHORT};
          dstat_nxt    = STAT_NONE;
          byte_cnt_nxt = '0;
          ovf_nxt      = 1'b0;
        end
      end
      S_EXC_CHK: begin
        if (srdata_r == 6'(SYM_ESC)) begin
          gbit_nxt   = exbit_r;
          gb_exc_nxt = 1'b1;
        end else begin
          sym_i_nxt = j_inc;
        end
      end
      S_FINISH: begin
        symcnt_nxt   = used_r;
        rp_nxt       = '0;
        prev_nxt     = 32'd0;
        emitted_nxt  = 24'd0;
        dstat_nxt    = (total_r != 24'd0) ? STAT_OK : STAT_NONE;
        byte_cnt_nxt = '0;
        ovf_nxt      = 1'b0;
        res_nxt = '{is_value: 1'b0, decoded_value: 32'd0, value_index: 14'd0,
                    last_value: 1'b0, value_count: total_r, status: STAT_OK};
      end
      S_FETCH_CHK: begin
        rp_nxt = rp_r + SW'(1);
        if (srdata_r != 6'd0) begin
          pos_nxt = npos;
          if (npos <= 6'd32) acc_nxt = acc_r | (32'd1 << npos_m1[4:0]);
        end
      end
      S_FETCH_DONE: begin
        prev_nxt    = acc_r ^ prev_r;
        emitted_nxt = emit_inc;
        if (emit_inc >= total_r) dstat_nxt = STAT_NONE;
        res_nxt = '{is_value: 1'b1, decoded_value: acc_r ^ prev_r,
                    value_index: emitted_r[13:0], last_value: emit_inc == total_r,
                    value_count: total_r, status: STAT_OK};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      byte_cnt_r <= '0;
      ovf_r      <= 1'b0;
      total_r    <= 24'd0;
      symcnt_r   <= '0;
      rp_r       <= '0;
      prev_r     <= 32'd0;
      emitted_r  <= 24'd0;
      dstat_r    <= STAT_NONE;
    end else begin
      state_r    <= state_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      ovf_r      <= ovf_nxt;
      total_r    <= total_nxt;
      symcnt_r   <= symcnt_nxt;
      rp_r       <= rp_nxt;
      prev_r     <= prev_nxt;
      emitted_r  <= emitted_nxt;
      dstat_r    <= dstat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r    <= hdr_nxt;
    bitp_r   <= bitp_nxt;
    gbit_r   <= gbit_nxt;
    lo_r     <= lo_nxt;
    sym_i_r  <= sym_i_nxt;
    used_r   <= used_nxt;
    zeros_r  <= zeros_nxt;
    want5_r  <= want5_nxt;
    endbit_r <= endbit_nxt;
    exbit_r  <= exbit_nxt;
    gb_exc_r <= gb_exc_nxt;
    acc_r    <= acc_nxt;
    pos_r    <= pos_nxt;
    res_r    <= res_nxt;
  end

endmodule

`default_nettype wire
